// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared immediate-implication and next-cycle property wrappers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)

`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== rtl/lwps_pkg.sv =====
// ----------------------------------------------------------------------------
// lwps_pkg
// Types and constants shared by the LCD window pixel streamer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lwps_pkg;

   localparam int PANEL_WIDTH  = 480;
   localparam int PANEL_HEIGHT = 320;

   localparam int COORD_W = 9;
   localparam int INDEX_W = 25;

   // job queue between front and back
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = QPTR_W + 1;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 9;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISPLAY_READY = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_X      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_Y      = 2'd2;

   // panel commands
   localparam logic [7:0] CMD_COLUMN_SET   = 8'h2A;
   localparam logic [7:0] CMD_ROW_SET      = 8'h2B;
   localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;

   typedef enum logic {
      REQ_RECT  = 1'b0,
      REQ_PIXEL = 1'b1
   } req_kind_type;

   typedef enum logic {
      JOB_WINDOW = 1'b0,
      JOB_PIXEL  = 1'b1
   } job_kind_type;

   typedef struct packed {
      logic               req_type;
      logic signed [15:0] rect_x;
      logic signed [15:0] rect_y;
      logic signed [15:0] rect_w;
      logic signed [15:0] rect_h;
      logic [15:0]        stride;
      logic [15:0]        pixel;
   } req_item_type;

   typedef struct packed {
      logic [7:0]         out_byte;
      logic               dc;
      logic [INDEX_W-1:0] source_index;
      logic               last;
      logic               window_done;
   } rsp_item_type;

   // one unit of work for the back end: a window header or one pixel
   typedef struct packed {
      job_kind_type       kind;
      logic [15:0]        pixel;
      logic [INDEX_W-1:0] index;
      logic               done;
      logic [COORD_W:0]   col_start;
      logic [COORD_W:0]   col_end;
      logic [COORD_W:0]   row_start;
      logic [COORD_W:0]   row_end;
   } job_type;

endpackage

// ===== rtl/lwps_front.sv =====
// ----------------------------------------------------------------------------
// lwps_front
// Accepts requests, clips windows, walks the raster and queues jobs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lwps_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  lwps_pkg::req_item_type              req_data,
   input  logic                                csr_wr_en,
   input  logic [lwps_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lwps_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [lwps_pkg::QCNT_W-1:0]         q_count,
   output logic                                q_wr_en,
   output lwps_pkg::job_type                   q_wr_data
);
   import lwps_pkg::*;

   localparam logic signed [16:0] X_LIMIT = 17'(PANEL_WIDTH);
   localparam logic signed [16:0] Y_LIMIT = 17'(PANEL_HEIGHT);
   localparam logic [QCNT_W:0]    Q_LIMIT = (QCNT_W+1)'(QDEPTH);

   // configuration
   logic               display_ready_ff;
   logic [COORD_W-1:0] offset_x_ff;
   logic [COORD_W-1:0] offset_y_ff;

   // stage 1: captured item with corner sums
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_kind_ff;
   logic [14:0]        s1_x0_ff, s1_y0_ff;
   logic signed [16:0] s1_x1_ff, s1_y1_ff;
   logic               s1_size_ok_ff;
   logic [15:0]        s1_stride_ff;
   logic [15:0]        s1_pixel_ff;

   // window walk state
   logic               window_open_ff, window_open_in;
   logic [COORD_W-1:0] window_left_ff, window_left_in;
   logic [COORD_W-1:0] window_right_ff, window_right_in;
   logic [COORD_W-1:0] window_bottom_ff, window_bottom_in;
   logic [COORD_W-1:0] current_column_ff, current_column_in;
   logic [COORD_W-1:0] current_row_ff, current_row_in;
   logic [INDEX_W-1:0] row_base_ff, row_base_in;
   logic [15:0]        held_stride_ff, held_stride_in;

   logic               accept;
   logic [QCNT_W:0]    pending;
   logic signed [16:0] x_sum, y_sum;
   logic signed [16:0] x0_ext, y0_ext;
   logic               win_ok;
   logic [INDEX_W-1:0] base_prod;
   logic [INDEX_W-1:0] pix_index;
   logic               at_right, at_bottom;
   logic [COORD_W-1:0] right_in, bottom_in;

   // credit check: every item in flight may still need a queue slot
   assign pending  = {1'b0, q_count} + {{QCNT_W{1'b0}}, s1_valid_ff};
   assign req_full = (pending >= Q_LIMIT);
   assign accept   = req_push && !req_full;

   assign x_sum = $signed({req_data.rect_x[15], req_data.rect_x})
                + $signed({req_data.rect_w[15], req_data.rect_w});
   assign y_sum = $signed({req_data.rect_y[15], req_data.rect_y})
                + $signed({req_data.rect_h[15], req_data.rect_h});

   assign s1_valid_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (accept) begin
         s1_kind_ff    <= req_data.req_type;
         s1_x0_ff      <= req_data.rect_x[15] ? 15'd0 : req_data.rect_x[14:0];
         s1_y0_ff      <= req_data.rect_y[15] ? 15'd0 : req_data.rect_y[14:0];
         s1_x1_ff      <= (x_sum < X_LIMIT) ? x_sum : X_LIMIT;
         s1_y1_ff      <= (y_sum < Y_LIMIT) ? y_sum : Y_LIMIT;
         s1_size_ok_ff <= !req_data.rect_w[15] && (req_data.rect_w != 16'sd0) &&
                          !req_data.rect_h[15] && (req_data.rect_h != 16'sd0);
         s1_stride_ff  <= req_data.stride;
         s1_pixel_ff   <= req_data.pixel;
      end
   end

   // stage 2: window decision and raster walk
   assign x0_ext = $signed({2'b00, s1_x0_ff});
   assign y0_ext = $signed({2'b00, s1_y0_ff});
   assign win_ok = display_ready_ff && s1_size_ok_ff &&
                   (s1_x1_ff > x0_ext) && (s1_y1_ff > y0_ext);

   assign right_in  = s1_x1_ff[COORD_W-1:0] - COORD_W'(1);
   assign bottom_in = s1_y1_ff[COORD_W-1:0] - COORD_W'(1);
   assign base_prod = {16'd0, s1_y0_ff[COORD_W-1:0]} * {9'd0, s1_stride_ff};

   assign pix_index = row_base_ff + {16'd0, current_column_ff};
   assign at_right  = (current_column_ff == window_right_ff);
   assign at_bottom = (current_row_ff == window_bottom_ff);

   always_comb begin
      window_open_in    = window_open_ff;
      window_left_in    = window_left_ff;
      window_right_in   = window_right_ff;
      window_bottom_in  = window_bottom_ff;
      current_column_in = current_column_ff;
      current_row_in    = current_row_ff;
      row_base_in       = row_base_ff;
      held_stride_in    = held_stride_ff;
      q_wr_en           = 1'b0;

      q_wr_data.kind      = JOB_PIXEL;
      q_wr_data.pixel     = s1_pixel_ff;
      q_wr_data.index     = pix_index;
      q_wr_data.done      = at_right && at_bottom;
      q_wr_data.col_start = {1'b0, s1_x0_ff[COORD_W-1:0]} + {1'b0, offset_x_ff};
      q_wr_data.col_end   = {1'b0, right_in} + {1'b0, offset_x_ff};
      q_wr_data.row_start = {1'b0, s1_y0_ff[COORD_W-1:0]} + {1'b0, offset_y_ff};
      q_wr_data.row_end   = {1'b0, bottom_in} + {1'b0, offset_y_ff};

      if (s1_valid_ff) begin
         if (s1_kind_ff == REQ_RECT) begin
            // a rectangle request closes the open window first
            q_wr_data.kind = JOB_WINDOW;
            window_open_in = win_ok;
            q_wr_en        = win_ok;
            if (win_ok) begin
               window_left_in    = s1_x0_ff[COORD_W-1:0];
               window_right_in   = right_in;
               window_bottom_in  = bottom_in;
               current_column_in = s1_x0_ff[COORD_W-1:0];
               current_row_in    = s1_y0_ff[COORD_W-1:0];
               row_base_in       = base_prod;
               held_stride_in    = s1_stride_ff;
            end
         end else if (window_open_ff) begin
            q_wr_en = 1'b1;
            if (at_right) begin
               current_column_in = window_left_ff;
               if (at_bottom) begin
                  window_open_in = 1'b0;
               end else begin
                  current_row_in = current_row_ff + COORD_W'(1);
                  row_base_in    = row_base_ff + {9'd0, held_stride_ff};
               end
            end else begin
               current_column_in = current_column_ff + COORD_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_open_ff <= 1'b0;
      end else begin
         window_open_ff <= window_open_in;
      end
      window_left_ff    <= window_left_in;
      window_right_ff   <= window_right_in;
      window_bottom_ff  <= window_bottom_in;
      current_column_ff <= current_column_in;
      current_row_ff    <= current_row_in;
      row_base_ff       <= row_base_in;
      held_stride_ff    <= held_stride_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         display_ready_ff <= 1'b0;
         offset_x_ff      <= '0;
         offset_y_ff      <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_DISPLAY_READY: display_ready_ff <= csr_wdata[0];
            CSR_OFFSET_X:      offset_x_ff      <= csr_wdata;
            CSR_OFFSET_Y:      offset_y_ff      <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

endmodule

// ===== rtl/lwps_queue.sv =====
// ----------------------------------------------------------------------------
// lwps_queue
// Short job queue decoupling the front end from the byte sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lwps_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  lwps_pkg::job_type           wr_data,
   input  logic                        rd_en,
   output lwps_pkg::job_type           head,
   output logic                        empty,
   output logic [lwps_pkg::QCNT_W-1:0] count
);
   import lwps_pkg::*;

   job_type            mem_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign head  = mem_ff[rd_ptr_ff];
   assign empty = (count_ff == '0);
   assign count = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(wr_en);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(rd_en);
      count_in  = count_ff + QCNT_W'(wr_en) - QCNT_W'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== rtl/lwps_back.sv =====
// ----------------------------------------------------------------------------
// lwps_back
// Byte sequencer: expands queued jobs into link words, one per cycle unless the output word is held unpopped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lwps_back (
   input  logic                   clock,
   input  logic                   reset,
   input  lwps_pkg::job_type      q_head,
   input  logic                   q_empty,
   output logic                   q_rd_en,
   input  logic                   rsp_pop,
   output logic                   rsp_empty,
   output lwps_pkg::rsp_item_type rsp_data
);
   import lwps_pkg::*;

   // word slots of a window header
   localparam logic [3:0] SLOT_COL_CMD = 4'd0;
   localparam logic [3:0] SLOT_CS_HI   = 4'd1;
   localparam logic [3:0] SLOT_CS_LO   = 4'd2;
   localparam logic [3:0] SLOT_CE_HI   = 4'd3;
   localparam logic [3:0] SLOT_CE_LO   = 4'd4;
   localparam logic [3:0] SLOT_ROW_CMD = 4'd5;
   localparam logic [3:0] SLOT_RS_HI   = 4'd6;
   localparam logic [3:0] SLOT_RS_LO   = 4'd7;
   localparam logic [3:0] SLOT_RE_HI   = 4'd8;
   localparam logic [3:0] SLOT_RE_LO   = 4'd9;
   localparam logic [3:0] SLOT_MW_CMD  = 4'd10;
   // word slots of a pixel
   localparam logic [3:0] SLOT_RED     = 4'd0;
   localparam logic [3:0] SLOT_GREEN   = 4'd1;
   localparam logic [3:0] SLOT_BLUE    = 4'd2;

   logic         cur_valid_ff, cur_valid_in;
   job_type      cur_ff;
   logic [3:0]   slot_ff, slot_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_ff;
   rsp_item_type word;

   logic out_free;
   logic emit;
   logic final_word;
   logic take;

   assign out_free   = !rsp_valid_ff || rsp_pop;
   assign emit       = cur_valid_ff && out_free;
   assign final_word = emit && (cur_ff.kind == JOB_PIXEL ? (slot_ff == SLOT_BLUE)
                                                         : (slot_ff == SLOT_MW_CMD));
   assign take       = (!cur_valid_ff || final_word) && !q_empty;
   assign q_rd_en    = take;

   always_comb begin
      word.out_byte     = 8'h00;
      word.dc           = 1'b1;
      word.source_index = '0;
      word.last         = 1'b0;
      word.window_done  = 1'b0;
      if (cur_ff.kind == JOB_PIXEL) begin
         word.source_index = cur_ff.index;
         case (slot_ff)
            SLOT_RED:   word.out_byte = {cur_ff.pixel[15:11], 3'b000};
            SLOT_GREEN: word.out_byte = {cur_ff.pixel[10:5], 2'b00};
            SLOT_BLUE: begin
               word.out_byte    = {cur_ff.pixel[4:0], 3'b000};
               word.last        = 1'b1;
               word.window_done = cur_ff.done;
            end
            default: word.out_byte = 8'h00;
         endcase
      end else begin
         case (slot_ff)
            SLOT_COL_CMD: begin
               word.out_byte = CMD_COLUMN_SET;
               word.dc       = 1'b0;
            end
            SLOT_CS_HI:   word.out_byte = {6'd0, cur_ff.col_start[COORD_W:8]};
            SLOT_CS_LO:   word.out_byte = cur_ff.col_start[7:0];
            SLOT_CE_HI:   word.out_byte = {6'd0, cur_ff.col_end[COORD_W:8]};
            SLOT_CE_LO:   word.out_byte = cur_ff.col_end[7:0];
            SLOT_ROW_CMD: begin
               word.out_byte = CMD_ROW_SET;
               word.dc       = 1'b0;
            end
            SLOT_RS_HI:   word.out_byte = {6'd0, cur_ff.row_start[COORD_W:8]};
            SLOT_RS_LO:   word.out_byte = cur_ff.row_start[7:0];
            SLOT_RE_HI:   word.out_byte = {6'd0, cur_ff.row_end[COORD_W:8]};
            SLOT_RE_LO:   word.out_byte = cur_ff.row_end[7:0];
            SLOT_MW_CMD: begin
               word.out_byte = CMD_MEMORY_WRITE;
               word.dc       = 1'b0;
               word.last     = 1'b1;
            end
            default:      word.out_byte = 8'h00;
         endcase
      end
   end

   always_comb begin
      cur_valid_in = cur_valid_ff;
      slot_in      = slot_ff;
      if (take) begin
         cur_valid_in = 1'b1;
         slot_in      = '0;
      end else if (final_word) begin
         cur_valid_in = 1'b0;
      end else if (emit) begin
         slot_in = slot_ff + 4'd1;
      end

      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (take) begin
         cur_ff <= q_head;
      end
      if (emit) begin
         rsp_ff <= word;
      end
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/lcd_window_pixel_streamer.sv =====
// Path: an accepted word is registered in stage 1, queued as a job, loaded into
//   the back end, then registered as an output word. One output word per cycle
//   while popped, from a single output register; a window request gives 11 words, a pixel 3.
// Rejected requests and dropped pixels pass through front stage 1 and queue no job.
// Reset is synchronous, active high: clears control registers, queue and open window.
// ----------------------------------------------------------------------------
// lcd_window_pixel_streamer
// SPI LCD window/pixel byte engine: clips a rectangle, emits the address-set
// header, then widens each RGB565 pixel of the window into three RGB666 bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lcd_window_pixel_streamer (
   input  logic                             clock,
   input  logic                             reset,
   // request side
   input  logic                             req_push,
   output logic                             req_full,
   input  lwps_pkg::req_item_type           req_data,
   // result side
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output lwps_pkg::rsp_item_type           rsp_data,
   // register writes
   input  logic                             csr_wr_en,
   input  logic [lwps_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lwps_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import lwps_pkg::*;

   // Front: two-stage pipe. Stage 1 registers the word and the clip sums
   // (corner + size, clamped to the panel edge). Stage 2 decides whether the
   // window is live, takes y0*stride as the first row base, and walks the
   // raster for pixel words, pushing one job per emitting word into the queue.
   // The front only accepts when the queue has a slot for every word in flight.
   logic              q_wr_en;
   job_type           q_wr_data;
   logic              q_rd_en;
   job_type           q_head;
   logic              q_empty;
   logic [QCNT_W-1:0] q_count;

   lwps_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_count   (q_count),
      .q_wr_en   (q_wr_en),
      .q_wr_data (q_wr_data)
   );

   // Job queue: lets the front run ahead while the back drains bytes.
   lwps_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_wr_en),
      .wr_data (q_wr_data),
      .rd_en   (q_rd_en),
      .head    (q_head),
      .empty   (q_empty),
      .count   (q_count)
   );

   // Back: holds one job and steps a slot counter through its words; the next
   // job is loaded on the final word so consecutive jobs run without a gap.
   lwps_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_head    (q_head),
      .q_empty   (q_empty),
      .q_rd_en   (q_rd_en),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

   // credit check must keep the queue from overrunning
   `ASSERT_IMPLY(a_queue_room, clock, reset, q_wr_en, q_count < QCNT_W'(QDEPTH), "job queue overrun")
   // back end never reads a job that is not there
   `ASSERT_IMPLY(a_queue_read, clock, reset, q_rd_en, !q_empty, "job read from empty queue")
   // a written job is visible in the queue on the next cycle
   `ASSERT_NEXT(a_queue_fill, clock, reset, q_wr_en, !q_empty, "queue lost a written job")
   // window completion only ever marks the last data word of a pixel
   `ASSERT_IMPLY(a_done_last, clock, reset, !rsp_empty && rsp_data.window_done, rsp_data.last && rsp_data.dc, "window_done off a pixel's last word")

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LCD window pixel streamer. A scoreboard class
// predicts the link bytes of every accepted word (window header or widened
// pixel) and checks each popped result word field by field. Directed words
// cover clipping, rejects, dropped pixels and register corners; random
// windows with random idling on both sides follow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import lwps_pkg::*;

class lcd_byte_predictor;
   // register copies
   logic              ready;
   logic [8:0]        col_offset;
   logic [8:0]        row_offset;
   // open window and raster position
   logic              win_open;
   logic [8:0]        win_left;
   logic [8:0]        win_right;
   logic [8:0]        win_bottom;
   logic [8:0]        col;
   logic [8:0]        row;
   logic [24:0]       row_base;
   logic [15:0]       row_stride;
   rsp_item_type      expected_bytes[$];
   int unsigned       errors;

   function new();
      ready      = 1'b0;
      col_offset = '0;
      row_offset = '0;
      win_open   = 1'b0;
      win_left   = '0;
      win_right  = '0;
      win_bottom = '0;
      col        = '0;
      row        = '0;
      row_base   = '0;
      row_stride = '0;
      errors     = 0;
   endfunction

   function void set_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_DISPLAY_READY: ready = data[0];
         CSR_OFFSET_X:      col_offset = data;
         CSR_OFFSET_Y:      row_offset = data;
         default: ;
      endcase
   endfunction

   function void add_word(logic [7:0] b, logic dc, logic [24:0] idx, logic last,
                          logic done);
      rsp_item_type e;
      e.out_byte     = b;
      e.dc           = dc;
      e.source_index = idx;
      e.last         = last;
      e.window_done  = done;
      expected_bytes.push_back(e);
   endfunction

   // clip to the panel and queue the address-set header
   function int open_window(req_item_type w);
      int          rx, ry, rw, rh;
      int          x0, y0, x1, y1;
      logic [15:0] cs, ce, rs, re;
      rx = $signed(w.rect_x);
      ry = $signed(w.rect_y);
      rw = $signed(w.rect_w);
      rh = $signed(w.rect_h);
      win_open = 1'b0;
      if (!ready || rw <= 0 || rh <= 0) return 0;
      x0 = (rx > 0) ? rx : 0;
      y0 = (ry > 0) ? ry : 0;
      x1 = (rx + rw < PANEL_WIDTH) ? rx + rw : PANEL_WIDTH;
      y1 = (ry + rh < PANEL_HEIGHT) ? ry + rh : PANEL_HEIGHT;
      if (x1 <= x0 || y1 <= y0) return 0;

      win_open   = 1'b1;
      win_left   = 9'(x0);
      win_right  = 9'(x1 - 1);
      win_bottom = 9'(y1 - 1);
      col        = 9'(x0);
      row        = 9'(y0);
      row_stride = w.stride;
      row_base   = 25'(y0 * int'(w.stride));

      cs = 16'(x0 + int'(col_offset));
      ce = 16'(x1 - 1 + int'(col_offset));
      rs = 16'(y0 + int'(row_offset));
      re = 16'(y1 - 1 + int'(row_offset));

      add_word(CMD_COLUMN_SET, 1'b0, '0, 1'b0, 1'b0);
      add_word(cs[15:8], 1'b1, '0, 1'b0, 1'b0);
      add_word(cs[7:0], 1'b1, '0, 1'b0, 1'b0);
      add_word(ce[15:8], 1'b1, '0, 1'b0, 1'b0);
      add_word(ce[7:0], 1'b1, '0, 1'b0, 1'b0);
      add_word(CMD_ROW_SET, 1'b0, '0, 1'b0, 1'b0);
      add_word(rs[15:8], 1'b1, '0, 1'b0, 1'b0);
      add_word(rs[7:0], 1'b1, '0, 1'b0, 1'b0);
      add_word(re[15:8], 1'b1, '0, 1'b0, 1'b0);
      add_word(re[7:0], 1'b1, '0, 1'b0, 1'b0);
      add_word(CMD_MEMORY_WRITE, 1'b0, '0, 1'b1, 1'b0);
      return 11;
   endfunction

   // RGB565 to three RGB666 bytes, then advance in raster order
   function int widen_pixel(logic [15:0] px);
      logic [24:0] idx;
      logic        fin;
      if (!win_open) return 0;
      idx = row_base + 25'(col);
      fin = (col == win_right) && (row == win_bottom);
      add_word({px[15:11], 3'b000}, 1'b1, idx, 1'b0, 1'b0);
      add_word({px[10:5], 2'b00}, 1'b1, idx, 1'b0, 1'b0);
      add_word({px[4:0], 3'b000}, 1'b1, idx, 1'b1, fin);
      if (col == win_right) begin
         col = win_left;
         if (row == win_bottom) begin
            win_open = 1'b0;
         end else begin
            row      = row + 9'd1;
            row_base = row_base + 25'(row_stride);
         end
      end else begin
         col = col + 9'd1;
      end
      return 3;
   endfunction

   // returns the number of result words the accepted word causes
   function int note_request(req_item_type w);
      if (w.req_type == REQ_RECT) return open_window(w);
      return widen_pixel(w.pixel);
   endfunction

   function int pixels_left();
      if (!win_open) return 0;
      return (int'(win_bottom) - int'(row)) * (int'(win_right) - int'(win_left) + 1)
             + int'(win_right) - int'(col) + 1;
   endfunction

   function void check_word(rsp_item_type got);
      rsp_item_type want;
      if (expected_bytes.size() == 0) begin
         $error("result word %0h with no expectation waiting", got);
         errors++;
         return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte) begin
         $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
         errors++;
      end
      if (got.dc !== want.dc) begin
         $error("dc: expected %0h, got %0h", want.dc, got.dc);
         errors++;
      end
      if (got.source_index !== want.source_index) begin
         $error("source_index: expected %0h, got %0h", want.source_index,
                got.source_index);
         errors++;
      end
      if (got.last !== want.last) begin
         $error("last: expected %0h, got %0h", want.last, got.last);
         errors++;
      end
      if (got.window_done !== want.window_done) begin
         $error("window_done: expected %0h, got %0h", want.window_done, got.window_done);
         errors++;
      end
   endfunction
endclass

module tb_top;

   // unused register index; writes to it must have no effect
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   // a rejected request or dropped pixel leaves the front pipe without any
   // result; wait this long before touching registers
   localparam int SETTLE_CYCLES = 12;
   // new random rounds start until this many words went in, directed ones included
   localparam int ITEM_TARGET   = 90;
   // slowest legal run is around 1 ms; give it ten times that
   localparam int unsigned TIMEOUT_NS = 10_000_000;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_push  = 1'b0;
   logic                   req_full;
   req_item_type           req_data  = '0;
   logic                   rsp_empty;
   logic                   rsp_pop   = 1'b0;
   rsp_item_type           rsp_data;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // steady: no idling on either side for the current phase
   bit                     steady    = 1'b0;
   int                     pop_hold  = 0;
   int                     sent_items = 0;

   lcd_byte_predictor      predictor;

   lcd_window_pixel_streamer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // mostly short idle stretches, now and then a long one
   function automatic int idle_length();
      return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
   endfunction

   // receiver: random pop stalls, which land on header and pixel bytes alike
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (pop_hold != 0) begin
         rsp_pop  <= 1'b0;
         pop_hold <= pop_hold - 1;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
         rsp_pop  <= 1'b0;
         pop_hold <= idle_length() - 1;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // every popped word goes to the scoreboard; values are pre-edge samples
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) predictor.check_word(rsp_data);
   end

   // all fields but the kind random, so the unused fields of each word toggle too
   function automatic req_item_type random_word();
      req_item_type r;
      r.req_type = REQ_PIXEL;
      r.rect_x   = 16'($urandom);
      r.rect_y   = 16'($urandom);
      r.rect_w   = 16'($urandom);
      r.rect_h   = 16'($urandom);
      r.stride   = 16'($urandom);
      r.pixel    = 16'($urandom);
      return r;
   endfunction

   function automatic req_item_type rect_word(int x, int y, int w, int h,
                                              logic [15:0] stride);
      req_item_type r;
      r          = random_word();
      r.req_type = REQ_RECT;
      r.rect_x   = 16'(x);
      r.rect_y   = 16'(y);
      r.rect_w   = 16'(w);
      r.rect_h   = 16'(h);
      r.stride   = stride;
      return r;
   endfunction

   function automatic req_item_type pixel_word(logic [15:0] px);
      req_item_type r;
      r       = random_word();
      r.pixel = px;
      return r;
   endfunction

   // Push one word. push is only lowered when a gap is wanted, so back-to-back
   // words never see a low/high pair of assignments in one time step.
   task automatic send_word(input req_item_type w);
      int gap;
      gap = steady ? 0 : ($urandom_range(0, 1) ? 0 : idle_length());
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_full);
      void'(predictor.note_request(w));
      sent_items++;
   endtask

   // wait for every expected word, then let silent words clear the pipe
   task automatic drain();
      req_push <= 1'b0;
      do @(posedge clock); while (predictor.expected_bytes.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write all three registers plus the unused index; block must be idle
   task automatic configure(input logic ready, input logic [8:0] ox, input logic [8:0] oy);
      logic [CSR_INDEX_W-1:0] idx [4];
      logic [CSR_DATA_W-1:0]  val [4];
      idx = '{CSR_DISPLAY_READY, CSR_OFFSET_X, CSR_OFFSET_Y, CSR_SPARE};
      // upper bits of the ready write are junk; only bit 0 counts
      val = '{{8'($urandom), ready}, ox, oy, 9'($urandom)};
      csr_wr_en <= 1'b1;
      foreach (idx[i]) begin
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
         predictor.set_register(idx[i], val[i]);
      end
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [8:0] pick_offset();
      case ($urandom_range(0, 3))
         0:       return 9'd0;
         1:       return 9'd511;
         default: return 9'($urandom);
      endcase
   endfunction

   // coordinate near the low edge, near the high edge, or anywhere on panel
   function automatic int edge_coord(int span);
      case ($urandom_range(0, 2))
         0:       return int'($urandom_range(0, 10)) - 5;
         1:       return span - int'($urandom_range(1, 10));
         default: return int'($urandom_range(0, span - 1));
      endcase
   endfunction

   task automatic run_directed();
      // registers still at reset: ready low, so a good rectangle is refused
      send_word(rect_word(0, 0, 4, 4, 16'd10));
      // stray pixel with no window open is dropped
      send_word(pixel_word(16'hFFFF));
      drain();
      configure(1'b1, 9'd511, 9'd511);
      // whole panel through a huge request, abandoned after two pixels
      send_word(rect_word(0, 0, 32767, 32767, 16'hFFFF));
      send_word(pixel_word(16'h0000));
      send_word(pixel_word(16'hFFFF));
      // zero width, most negative height
      send_word(rect_word(10, 10, 0, 5, 16'd1));
      send_word(rect_word(10, 10, 5, -32768, 16'd1));
      // entirely off the panel: left, right, below
      send_word(rect_word(-32768, 0, 100, 10, 16'd1));
      send_word(rect_word(PANEL_WIDTH, 0, 4, 4, 16'd1));
      send_word(rect_word(0, 32767, 4, 4, 16'd1));
      // single bottom-right pixel, then one too many
      send_word(rect_word(PANEL_WIDTH - 1, PANEL_HEIGHT - 1, 1, 1, 16'hFFFF));
      send_word(pixel_word(16'hF800));
      send_word(pixel_word(16'h07E0));
      // clipped on top and left to 3 x 2, each color channel alone
      send_word(rect_word(-5, -3, 8, 5, 16'd640));
      send_word(pixel_word(16'h001F));
      send_word(pixel_word(16'h07E0));
      send_word(pixel_word(16'hF800));
      send_word(pixel_word(16'hAAAA));
      send_word(pixel_word(16'h5555));
      send_word(pixel_word(16'h8410));
      drain();
      configure(1'b1, 9'd0, 9'd0);
      send_word(rect_word(100, 200, 2, 1, 16'd480));
      send_word(pixel_word(16'h1234));
      // ready dropped with the window half sent: the rest still goes out,
      // but the next rectangle is refused
      drain();
      configure(1'b0, 9'd0, 9'd0);
      send_word(pixel_word(16'h7BEF));
      send_word(rect_word(0, 0, 1, 1, 16'd0));
      drain();
   endtask

   // one rectangle and its pixels; a broken one stops short or overruns
   task automatic send_window(input bit complete);
      int          x, y, w, h, n;
      bit          huge, regs_midway;
      logic [15:0] stride;
      x    = edge_coord(PANEL_WIDTH);
      y    = edge_coord(PANEL_HEIGHT);
      w    = $urandom_range(1, 6);
      h    = $urandom_range(1, 4);
      huge = ($urandom_range(0, 7) == 0);
      if (huge) begin
         w = $urandom_range(1, 32767);
         h = $urandom_range(1, 32767);
      end
      case ($urandom_range(0, 3))
         0:       stride = '0;
         1:       stride = 16'hFFFF;
         default: stride = 16'($urandom);
      endcase
      send_word(rect_word(x, y, w, h, stride));
      n = predictor.pixels_left();
      if (huge) begin
         n = $urandom_range(0, 4);
      end else if (!complete) begin
         n = $urandom_range(0, 1) ? int'($urandom_range(0, n)) : n + int'($urandom_range(1, 3));
      end
      regs_midway = (n > 1) && ($urandom_range(0, 5) == 0);
      for (int i = 0; i < n; i++) begin
         if (regs_midway && i == n / 2) begin
            drain();
            configure(1'($urandom), pick_offset(), pick_offset());
         end
         send_word(pixel_word(16'($urandom)));
      end
   endtask

   task automatic run_random();
      int kind;
      while (sent_items < ITEM_TARGET) begin
         drain();
         steady <= ($urandom_range(0, 3) == 0);
         configure($urandom_range(0, 5) != 0, pick_offset(), pick_offset());
         repeat ($urandom_range(2, 5)) begin
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
               send_window(1'b1);
            end else if (kind < 9) begin
               send_window(1'b0);
            end else begin
               // noise: fully random rectangle and a few stray pixels
               send_word(rect_word($urandom, $urandom, $urandom, $urandom, 16'($urandom)));
               repeat ($urandom_range(0, 3)) send_word(pixel_word(16'($urandom)));
            end
         end
      end
   endtask

   initial begin
      predictor = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_random();
      steady <= 1'b0;
      drain();
      if (predictor.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // hang guard
   initial begin
      #(TIMEOUT_NS);
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== lcd_window_pixel_streamer.f =====
+incdir+rtl
rtl/lwps_pkg.sv
rtl/lwps_front.sv
rtl/lwps_queue.sv
rtl/lwps_back.sv
rtl/lcd_window_pixel_streamer.sv
tb/tb_top.sv
